// ===== rtl/taq_pkg.sv =====
// shared types, sizes and index arithmetic for the timestamp anchor queue
package taq_pkg;

  localparam int unsigned ANCHOR_DEPTH = 128;
  localparam int unsigned IDX_W        = $clog2(ANCHOR_DEPTH);
  localparam int unsigned CNT_W        = $clog2(ANCHOR_DEPTH + 1);
  localparam int unsigned SUM_W        = CNT_W + 1;
  localparam int unsigned OFFSET_W     = 48;
  localparam int unsigned STAMP_W      = 33;
  localparam int unsigned ENTRIES_W    = 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ANCHOR_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(ANCHOR_DEPTH);

  // action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_TAKE   = 1'b1;

  typedef struct packed {
    logic                action;
    logic [OFFSET_W-1:0] consumed_offset;
    logic [OFFSET_W-1:0] start_offset;
    logic [STAMP_W-1:0]  stamp;
    logic                stamp_valid;
  } in_t;

  typedef struct packed {
    logic                 accepted;
    logic [STAMP_W-1:0]   stamp_out;
    logic                 stamp_out_valid;
    logic [ENTRIES_W-1:0] entries;
  } out_t;

  // request from the sequencer to the anchor memory
  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [OFFSET_W-1:0] wr_offset;
    logic [STAMP_W-1:0]  wr_stamp;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [STAMP_W-1:0]  stamp;
  } mem_rsp_t;

  // circular slot: (idx + n) modulo the depth, with n at most the depth
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(n);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/timestamp_anchor_queue_core.sv =====
// Ordered queue of (byte offset, timestamp) anchors for one elementary stream.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one transaction per
// demuxed packet (append) or decoded unit (take). Output channel out_valid_o /
// out_stall_i / out_data_o returns exactly one result per input transaction,
// in order. A transaction moves on a rising edge with valid high and stall low.
//
// One item is worked on at a time. The anchors sit in a memory with a
// registered read, and every anchor looked at goes through a read state and
// a compare state. An append first drops stale anchors (no compare when at
// most one is left), then stores its own if stamped and there is room; a take
// pops anchors from the head while they start before the cursor.
//
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when the following result is ready,
// the sequencer holds in its final step and accepts nothing until the output
// register frees.
//
// Reset empties the queue (head and count cleared) at once; memory contents
// are not cleared, as only live entries are ever read.
module timestamp_anchor_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  taq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output taq_pkg::out_t out_data_o
);

  taq_pkg::mem_req_t mem_req;
  taq_pkg::mem_rsp_t mem_rsp;

  taq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp)
  );

  taq_anchor_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

endmodule

// ===== rtl/taq_anchor_mem.sv =====
// anchor storage: offset and timestamp arrays, one write and one registered read port
module taq_anchor_mem (
  input  logic              clk_i,
  input  taq_pkg::mem_req_t req_i,
  output taq_pkg::mem_rsp_t rsp_o
);

  logic [taq_pkg::OFFSET_W-1:0] offset_mem [taq_pkg::ANCHOR_DEPTH];
  logic [taq_pkg::STAMP_W-1:0]  stamp_mem  [taq_pkg::ANCHOR_DEPTH];
  taq_pkg::mem_rsp_t            rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      offset_mem[req_i.wr_addr] <= req_i.wr_offset;
      stamp_mem[req_i.wr_addr]  <= req_i.wr_stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rsp_q.offset <= offset_mem[req_i.rd_addr];
      rsp_q.stamp  <= stamp_mem[req_i.rd_addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/taq_ctrl.sv =====
// sequencer: holds head and count, walks the queue through the memory, registers the result
module taq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  taq_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output taq_pkg::out_t     out_data_o,
  output taq_pkg::mem_req_t mem_req_o,
  input  taq_pkg::mem_rsp_t mem_rsp_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_APPEND,
    ST_TAKE_RD,
    ST_TAKE_CHK,
    ST_FINISH
  } state_e;

  state_e                      state_q;
  taq_pkg::in_t                item_q;
  logic [taq_pkg::IDX_W-1:0]   head_q;
  logic [taq_pkg::CNT_W-1:0]   count_q;
  logic                        res_accepted_q;
  logic [taq_pkg::STAMP_W-1:0] res_stamp_q;
  logic                        res_stamp_valid_q;
  taq_pkg::out_t               out_q;
  logic                        out_valid_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        older_than_cursor;
  logic [taq_pkg::IDX_W-1:0]   head_next;

  assign in_stall_o        = (state_q != ST_IDLE);
  assign in_fire           = in_valid_i && (state_q == ST_IDLE);
  assign out_free          = !out_valid_q || !out_stall_i;
  assign older_than_cursor = mem_rsp_i.offset < item_q.consumed_offset;
  assign head_next         = taq_pkg::slot_add(head_q, taq_pkg::CNT_W'(1));

  // reads look one past the head when pruning, at the head when taking
  always_comb begin
    mem_req_o           = '0;
    mem_req_o.wr_addr   = taq_pkg::slot_add(head_q, count_q);
    mem_req_o.wr_offset = item_q.start_offset;
    mem_req_o.wr_stamp  = item_q.stamp;
    mem_req_o.wr_en     = (state_q == ST_APPEND) && item_q.stamp_valid &&
                          (count_q < taq_pkg::DEPTH_CNT);
    unique case (state_q)
      ST_PRUNE_RD: begin
        mem_req_o.rd_en   = (count_q > taq_pkg::CNT_W'(1));
        mem_req_o.rd_addr = head_next;
      end
      ST_TAKE_RD: begin
        mem_req_o.rd_en   = (count_q != '0);
        mem_req_o.rd_addr = head_q;
      end
      default: begin
        mem_req_o.rd_en   = 1'b0;
        mem_req_o.rd_addr = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      head_q            <= '0;
      count_q           <= '0;
      out_valid_q       <= 1'b0;
      item_q            <= '0;
      res_accepted_q    <= 1'b0;
      res_stamp_q       <= '0;
      res_stamp_valid_q <= 1'b0;
      out_q             <= '0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            item_q            <= in_data_i;
            res_accepted_q    <= 1'b0;
            res_stamp_q       <= '0;
            res_stamp_valid_q <= 1'b0;
            state_q <= (in_data_i.action == taq_pkg::ACT_TAKE) ? ST_TAKE_RD : ST_PRUNE_RD;
          end
        end
        ST_PRUNE_RD: begin
          state_q <= (count_q > taq_pkg::CNT_W'(1)) ? ST_PRUNE_CHK : ST_APPEND;
        end
        ST_PRUNE_CHK: begin
          // drop the head while its successor starts before the cursor
          if (older_than_cursor) begin
            head_q  <= head_next;
            count_q <= count_q - taq_pkg::CNT_W'(1);
            state_q <= ST_PRUNE_RD;
          end else begin
            state_q <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          if (!item_q.stamp_valid) begin
            res_accepted_q <= 1'b1;
          end else if (count_q < taq_pkg::DEPTH_CNT) begin
            count_q        <= count_q + taq_pkg::CNT_W'(1);
            res_accepted_q <= 1'b1;
          end
          state_q <= ST_FINISH;
        end
        ST_TAKE_RD: begin
          state_q <= (count_q != '0) ? ST_TAKE_CHK : ST_FINISH;
        end
        ST_TAKE_CHK: begin
          if (older_than_cursor) begin
            res_stamp_q       <= mem_rsp_i.stamp;
            res_stamp_valid_q <= 1'b1;
            head_q            <= head_next;
            count_q           <= count_q - taq_pkg::CNT_W'(1);
            state_q           <= ST_TAKE_RD;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q.accepted        <= res_accepted_q;
            out_q.stamp_out       <= res_stamp_q;
            out_q.stamp_out_valid <= res_stamp_valid_q;
            out_q.entries         <= taq_pkg::ENTRIES_W'(count_q);
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= taq_pkg::DEPTH_CNT)
    else $error("anchor count above depth");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (count_q < taq_pkg::DEPTH_CNT) && (state_q == ST_APPEND))
    else $error("anchor write into a full queue");

  a_read_live_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> (count_q != '0) && !mem_req_o.wr_en)
    else $error("anchor read with no live entry");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      (count_q == $past(count_q) + taq_pkg::CNT_W'(1)) ||
      (count_q == $past(count_q) - taq_pkg::CNT_W'(1)))
    else $error("anchor count moved by more than one");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && !out_free |=> (state_q == ST_FINISH))
    else $error("result left before the output register was free");

endmodule

// ===== verif/tb_timestamp_anchor_queue_core.sv =====
// testbench for timestamp_anchor_queue_core: directed table then random anchor streams
`timescale 1ns / 100ps

module tb_timestamp_anchor_queue_core;

  localparam logic [taq_pkg::OFFSET_W-1:0] OFF_TOP      = '1;
  localparam logic [taq_pkg::STAMP_W-1:0]  PTS_TOP      = '1;
  localparam logic                         ACT_APPEND   = taq_pkg::ACT_APPEND;
  localparam logic                         ACT_TAKE     = taq_pkg::ACT_TAKE;
  localparam int                           RANDOM_ITEMS = 1600;
  localparam int                           TAIL_CYCLES  = 300;
  localparam int                           CYCLE_LIMIT  = 3_000_000;

  localparam int EP_STREAM = 0;
  localparam int EP_FILL   = 1;
  localparam int EP_NOISE  = 2;

  typedef struct packed {
    logic [taq_pkg::OFFSET_W-1:0] offset;
    logic [taq_pkg::STAMP_W-1:0]  stamp;
  } anchor_t;

  typedef struct packed {
    taq_pkg::in_t  item;
    logic          typed;
    taq_pkg::out_t reply;
  } dir_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid    = 1'b0;
  logic          in_stall_o;
  taq_pkg::in_t  in_data     = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  taq_pkg::out_t out_data_o;

  anchor_t       held_anchors[$];
  taq_pkg::out_t anchor_replies[$];
  dir_row_t      dir_rows[$];

  int          fail_count  = 0;
  int          cycle_count = 0;
  logic [15:0] stall_tick  = '0;
  int          hold_left   = 0;

  timestamp_anchor_queue_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // prune or pop on the predictor's own copy of the queue, return the reply
  function automatic taq_pkg::out_t anchor_step(input taq_pkg::in_t item);
    taq_pkg::out_t reply;
    anchor_t       fresh;
    reply = '0;
    if (item.action == ACT_APPEND) begin
      // drop the oldest anchor while the one after it starts before the cursor
      while (held_anchors.size() > 1 && held_anchors[1].offset < item.consumed_offset)
        held_anchors.delete(0);
      if (!item.stamp_valid) begin
        reply.accepted = 1'b1;
      end else if (held_anchors.size() < taq_pkg::ANCHOR_DEPTH) begin
        fresh.offset = item.start_offset;
        fresh.stamp  = item.stamp;
        held_anchors.push_back(fresh);
        reply.accepted = 1'b1;
      end
    end else begin
      while (held_anchors.size() > 0 && held_anchors[0].offset < item.consumed_offset) begin
        reply.stamp_out       = held_anchors[0].stamp;
        reply.stamp_out_valid = 1'b1;
        held_anchors.delete(0);
      end
    end
    reply.entries = taq_pkg::ENTRIES_W'(held_anchors.size());
    return reply;
  endfunction

  task automatic add_row(input logic act, input logic [taq_pkg::OFFSET_W-1:0] consumed,
                         input logic [taq_pkg::OFFSET_W-1:0] start,
                         input logic [taq_pkg::STAMP_W-1:0] stamp,
                         input logic stamp_valid, input logic typed, input logic acc,
                         input logic [taq_pkg::STAMP_W-1:0] stamp_out,
                         input logic stamp_out_valid,
                         input logic [taq_pkg::ENTRIES_W-1:0] entries);
    dir_row_t row;
    row.item.action                = act;
    row.item.consumed_offset       = consumed;
    row.item.start_offset          = start;
    row.item.stamp                 = stamp;
    row.item.stamp_valid           = stamp_valid;
    row.typed                      = typed;
    row.reply.accepted             = acc;
    row.reply.stamp_out            = stamp_out;
    row.reply.stamp_out_valid      = stamp_out_valid;
    row.reply.entries              = entries;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input taq_pkg::in_t item, input logic typed,
                           input taq_pkg::out_t typed_reply);
    taq_pkg::out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = anchor_step(item);
    anchor_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // always waits on the clock before it checks, so valid is never dropped and raised in one step
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (anchor_replies.size() != 0);
  endtask

  initial begin : stimulus
    taq_pkg::in_t                 item;
    logic [taq_pkg::OFFSET_W-1:0] wr_pos;
    logic [taq_pkg::OFFSET_W-1:0] rd_pos;
    logic [taq_pkg::STAMP_W-1:0]  pts;
    int                           sent;
    int                           episodes;
    int                           episode_left;
    int                           kind;
    int                           burst_left;
    int                           append_pct;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    //      act         consumed  start     stamp    sv    typ   acc   sout svld  ent
    add_row(ACT_TAKE,   OFF_TOP,  OFF_TOP,  PTS_TOP, 1'b1, 1'b1, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_APPEND, OFF_TOP,  OFF_TOP,  PTS_TOP, 1'b0, 1'b1, 1'b1, '0, 1'b0, 8'd0);
    add_row(ACT_APPEND, '0,       '0,       '0,      1'b1, 1'b1, 1'b1, '0, 1'b0, 8'd1);
    add_row(ACT_APPEND, '0,       48'd100,  PTS_TOP, 1'b1, 1'b1, 1'b1, '0, 1'b0, 8'd2);
    add_row(ACT_APPEND, '0,       48'd100,  33'd7,   1'b1, 1'b1, 1'b1, '0, 1'b0, 8'd3);
    add_row(ACT_APPEND, 48'd100,  48'd200,  33'd5,   1'b1, 1'b0, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_APPEND, 48'd101,  48'd300,  33'd9,   1'b1, 1'b0, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_TAKE,   '0,       OFF_TOP,  PTS_TOP, 1'b0, 1'b1, 1'b0, '0, 1'b0, 8'd3);
    add_row(ACT_TAKE,   48'd250,  '0,       '0,      1'b1, 1'b0, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_TAKE,   OFF_TOP,  '0,       '0,      1'b0, 1'b0, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_TAKE,   OFF_TOP,  '0,       '0,      1'b0, 1'b1, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_APPEND, OFF_TOP,  OFF_TOP,  PTS_TOP, 1'b1, 1'b1, 1'b1, '0, 1'b0, 8'd1);
    add_row(ACT_APPEND, OFF_TOP,  OFF_TOP,  '0,      1'b1, 1'b1, 1'b1, '0, 1'b0, 8'd2);
    add_row(ACT_TAKE,   OFF_TOP,  '0,       '0,      1'b0, 1'b1, 1'b0, '0, 1'b0, 8'd2);
    add_row(ACT_APPEND, OFF_TOP,  '0,       33'd3,   1'b0, 1'b1, 1'b1, '0, 1'b0, 8'd2);
    add_row(ACT_TAKE, '0, 48'hAAAA_AAAA_AAAA, 33'h0_5555_5555,
            1'b1, 1'b1, 1'b0, '0, 1'b0, 8'd2);
    add_row(ACT_TAKE, 48'h5555_5555_5555, 48'h5555_5555_5555, 33'h1_AAAA_AAAA,
            1'b0, 1'b0, 1'b0, '0, 1'b0, 8'd0);
    add_row(ACT_TAKE,   OFF_TOP,  '0,       '0,      1'b0, 1'b0, 1'b0, '0, 1'b0, 8'd0);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].reply);
      if (i % 3 == 2) idle_sender($urandom_range(1, 4));
    end
    drain_replies();

    wr_pos       = '0;
    rd_pos       = '0;
    pts          = taq_pkg::STAMP_W'({$urandom, $urandom});
    sent         = 0;
    episodes     = 0;
    episode_left = 0;
    kind         = EP_FILL;
    burst_left   = $urandom_range(1, 24);

    while (sent < RANDOM_ITEMS) begin
      if (episode_left == 0) begin
        // first run fills the queue so that a full queue is always reached
        if (episodes == 0) begin
          kind = EP_FILL;
        end else begin
          kind = $urandom_range(0, 9);
          kind = (kind < 6) ? EP_STREAM : (kind < 8) ? EP_FILL : EP_NOISE;
        end
        episode_left = (kind == EP_FILL)  ? $urandom_range(130, 160) :
                       (kind == EP_NOISE) ? $urandom_range(10, 30) : $urandom_range(40, 120);
        case ($urandom_range(0, 3))
          0: wr_pos = '0;
          1: wr_pos = taq_pkg::OFFSET_W'({$urandom, $urandom}) >> 1;
          2: wr_pos = OFF_TOP - taq_pkg::OFFSET_W'($urandom_range(0, 300000));
          default: ;
        endcase
        rd_pos = wr_pos;
        if (episodes != 0 && $urandom_range(0, 3) == 0) drain_replies();
        episodes++;
      end

      item = '0;
      if (kind == EP_NOISE) begin
        item.action          = 1'($urandom_range(0, 1));
        item.consumed_offset = ($urandom_range(0, 3) == 0) ? OFF_TOP :
                               ($urandom_range(0, 3) == 0) ? '0 :
                               taq_pkg::OFFSET_W'({$urandom, $urandom});
        item.start_offset    = taq_pkg::OFFSET_W'({$urandom, $urandom});
        item.stamp           = taq_pkg::STAMP_W'({$urandom, $urandom});
        item.stamp_valid     = 1'($urandom_range(0, 1));
      end else begin
        // the first run only appends stamped packets
        append_pct = (episodes == 1) ? 100 : (kind == EP_FILL) ? 92 : 55;
        if ($urandom_range(0, 99) < append_pct) begin
          item.action          = ACT_APPEND;
          item.consumed_offset = rd_pos;
          item.start_offset    = wr_pos;
          item.stamp           = pts;
          item.stamp_valid     = (episodes == 1) || ($urandom_range(0, 9) != 0);
          // a zero step gives anchors that share one start offset
          if (wr_pos <= OFF_TOP - 48'd4096)
            wr_pos += taq_pkg::OFFSET_W'($urandom_range(0, 4095));
          pts += taq_pkg::STAMP_W'($urandom_range(1, 6000));
        end else begin
          item.action = ACT_TAKE;
          if (kind == EP_STREAM && rd_pos <= OFF_TOP - 48'd8192)
            rd_pos += taq_pkg::OFFSET_W'($urandom_range(0, 3000));
          if (rd_pos > wr_pos) rd_pos = wr_pos + taq_pkg::OFFSET_W'($urandom_range(0, 1));
          item.consumed_offset = ($urandom_range(0, 19) == 0) ? OFF_TOP : rd_pos;
          item.start_offset    = taq_pkg::OFFSET_W'({$urandom, $urandom});
          item.stamp           = taq_pkg::STAMP_W'({$urandom, $urandom});
          item.stamp_valid     = 1'($urandom_range(0, 1));
        end
      end

      send_item(item, 1'b0, '0);
      sent++;
      episode_left--;

      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        // every third stretch of items runs back to back
        if ((sent / 320) % 3 != 1) idle_sender($urandom_range(1, 12));
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS timestamp_anchor_queue_core");
    end else begin
      $display("FAIL timestamp_anchor_queue_core");
    end
    $finish;
  end

  always @(posedge clk_i) begin : reply_check
    taq_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (anchor_replies.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_data_o);
        fail_count++;
      end else begin
        want = anchor_replies.pop_front();
        if (out_data_o.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data_o.accepted);
          fail_count++;
        end
        if (out_data_o.stamp_out !== want.stamp_out) begin
          $error("stamp_out: expected %0d, got %0d", want.stamp_out, out_data_o.stamp_out);
          fail_count++;
        end
        if (out_data_o.stamp_out_valid !== want.stamp_out_valid) begin
          $error("stamp_out_valid: expected %0d, got %0d",
                 want.stamp_out_valid, out_data_o.stamp_out_valid);
          fail_count++;
        end
        if (out_data_o.entries !== want.entries) begin
          $error("entries: expected %0d, got %0d", want.entries, out_data_o.entries);
          fail_count++;
        end
      end
    end

    // receiver stall pattern: free, random, periodic, then occasional long holds
    stall_tick <= stall_tick + 16'd1;
    case (stall_tick[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2'd2: out_stall_i <= ((stall_tick % 7) < 3);
      default: begin
        if (hold_left != 0) begin
          out_stall_i <= 1'b1;
          hold_left   <= hold_left - 1;
        end else if ($urandom_range(0, 24) == 0) begin
          out_stall_i <= 1'b1;
          hold_left   <= $urandom_range(5, 40);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL timestamp_anchor_queue_core");
      $finish;
    end
  end

endmodule
